// ===== rtl/core/oriented_box_point_sphere_test_assert.svh =====
// assertion macros shared by the oriented box test rtl
`ifndef ORIENTED_BOX_POINT_SPHERE_TEST_ASSERT_SVH
`define ORIENTED_BOX_POINT_SPHERE_TEST_ASSERT_SVH

// same-cycle implication, off while reset is held
`define OBPST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define OBPST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/obpst_pkg.sv =====
package obpst_pkg;

  // pipeline stages
  localparam int NSTG     = 7;
  localparam int ST_DIFF  = 0;
  localparam int ST_INNER = 1;
  localparam int ST_PROD  = 2;
  localparam int ST_ROUND = 3;
  localparam int ST_CLAMP = 4;
  localparam int ST_SQ    = 5;
  localparam int ST_SUM   = 6;

  // field widths
  localparam int POS_W = 16;
  localparam int H_W   = 15;
  localparam int R_W   = 15;
  localparam int QP_W  = 16;
  localparam int CFG_W = 32;
  localparam int IDX_W = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  // datapath widths
  localparam int V_W    = POS_W + 1;        // pos - center
  localparam int Q_W    = QP_W + 1;         // negated quaternion part
  localparam int I_W    = 34;               // first product sum
  localparam int P_W    = I_W + Q_W;        // second products
  localparam int S_W    = P_W + 1;          // sum of four products
  localparam int RND_SH = 28;
  localparam int L_W    = S_W - RND_SH;     // local coordinate
  localparam int SQ_W   = 2 * L_W;
  localparam int D2_W   = SQ_W + 2;
  localparam int R2_W   = 2 * R_W;

  localparam logic signed [S_W-1:0] RND_HALF = S_W'(64'd1 << (RND_SH - 1));

  typedef enum logic [IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_HALF_X   = 3'd3,
    CFG_HALF_Y   = 3'd4,
    CFG_HALF_Z   = 3'd5,
    CFG_QUAT_XY  = 3'd6,
    CFG_QUAT_ZW  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_ctl_t;

  // conjugate quaternion, sign extended
  typedef struct packed {
    logic signed [Q_W-1:0] a;
    logic signed [Q_W-1:0] b;
    logic signed [Q_W-1:0] c;
    logic signed [Q_W-1:0] w;
  } quat_conj_t;

  typedef struct packed {
    logic [H_W-1:0] hx;
    logic [H_W-1:0] hy;
    logic [H_W-1:0] hz;
  } half_ext_t;

endpackage

// ===== rtl/core/oriented_box_point_sphere_test.sv =====
// oriented box point containment and sphere overlap test
//
// in channel: one beat per query, pos_x/pos_y/pos_z signed Q8.8 and radius
//   unsigned Q7.8; a zero radius gives a plain point query
// out channel: one beat per query in the same order, inside_res and overlaps
// cfg port: cfg_we writes register cfg_addr (center xyz, half extents xyz,
//   quat_xy, quat_zw) from cfg_wdata; write only while idle
// datapath: offset from center, two quaternion product stages, rounding to
//   Q8.8, per-axis clamp, squares, sum and compare against radius squared
// throughput: one beat per cycle while the output is not held, set by the seven-stage
//   pipeline; every multiply stage is registered
// stall: each stage holds its beat only while the stage after it is full and held,
//   so the input keeps taking beats into bubbles while the output waits
// reset: pipeline emptied, registers back to unit box at the origin with
//   identity orientation
`include "oriented_box_point_sphere_test_assert.svh"

module oriented_box_point_sphere_test (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: pos_x [15:0], pos_y [31:16], pos_z [47:32], radius [62:48]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [obpst_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: inside_res [0], overlaps [1]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [obpst_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_we,
  input  logic [obpst_pkg::IDX_W-1:0]          cfg_addr,
  input  logic [obpst_pkg::CFG_W-1:0]          cfg_wdata
);
  import obpst_pkg::*;

  // box registers
  logic [POS_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [H_W-1:0]   half_x_r, half_y_r, half_z_r;
  logic [CFG_W-1:0] quat_xy_r, quat_zw_r;

  pipe_ctl_t        ctl;
  quat_conj_t       quat;
  half_ext_t        half;

  logic signed [L_W-1:0] loc_x, loc_y, loc_z;
  logic [R_W-1:0]        rad_loc;
  logic                  inside_res;
  logic                  overlaps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      half_x_r   <= H_W'(256);
      half_y_r   <= H_W'(256);
      half_z_r   <= H_W'(256);
      quat_xy_r  <= '0;
      quat_zw_r  <= CFG_W'(32'h4000_0000);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_CENTER_X: center_x_r <= cfg_wdata[POS_W-1:0];
        CFG_CENTER_Y: center_y_r <= cfg_wdata[POS_W-1:0];
        CFG_CENTER_Z: center_z_r <= cfg_wdata[POS_W-1:0];
        CFG_HALF_X:   half_x_r   <= cfg_wdata[H_W-1:0];
        CFG_HALF_Y:   half_y_r   <= cfg_wdata[H_W-1:0];
        CFG_HALF_Z:   half_z_r   <= cfg_wdata[H_W-1:0];
        CFG_QUAT_XY:  quat_xy_r  <= cfg_wdata;
        CFG_QUAT_ZW:  quat_zw_r  <= cfg_wdata;
      endcase
    end
  end

  // conjugate: negate the vector part, sign extended one bit so -(-2.0) fits
  always_comb begin
    quat.a = Q_W'(0) - {quat_xy_r[QP_W-1], quat_xy_r[QP_W-1:0]};
    quat.b = Q_W'(0) - {quat_xy_r[CFG_W-1], quat_xy_r[CFG_W-1:QP_W]};
    quat.c = Q_W'(0) - {quat_zw_r[QP_W-1], quat_zw_r[QP_W-1:0]};
    quat.w = {quat_zw_r[CFG_W-1], quat_zw_r[CFG_W-1:QP_W]};
    half.hx = half_x_r;
    half.hy = half_y_r;
    half.hz = half_z_r;
  end

  // handshake and stage enables
  obpst_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .ctl       (ctl)
  );

  // stages 0 to 3: box-local coordinates
  obpst_rot u_rot (
    .clk      (clk),
    .ctl      (ctl),
    .pos_x    (in_tdata[15:0]),
    .pos_y    (in_tdata[31:16]),
    .pos_z    (in_tdata[47:32]),
    .radius   (in_tdata[62:48]),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .center_z (center_z_r),
    .quat     (quat),
    .loc_x    (loc_x),
    .loc_y    (loc_y),
    .loc_z    (loc_z),
    .radius_o (rad_loc)
  );

  // stages 4 to 6: containment and sphere distance
  obpst_dist u_dist (
    .clk        (clk),
    .ctl        (ctl),
    .loc_x      (loc_x),
    .loc_y      (loc_y),
    .loc_z      (loc_z),
    .radius     (rad_loc),
    .half       (half),
    .inside_res (inside_res),
    .overlaps   (overlaps)
  );

  assign out_tdata = {(OUT_TDATA_W - 2)'(0), overlaps, inside_res};

  // a contained center always overlaps, any radius
  `OBPST_ASSERT_NOW(a_inside_overlaps, clk, rst_n, (out_tvalid && inside_res), overlaps,
    "inside without overlap")

endmodule

// ===== rtl/core/obpst_ctl.sv =====
`include "oriented_box_point_sphere_test_assert.svh"

module obpst_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output obpst_pkg::pipe_ctl_t ctl
);
  import obpst_pkg::*;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;
  logic            in_acc;
  logic            out_acc;

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign ctl.en    = en;
  assign in_acc    = in_valid && en[0];
  assign out_acc   = vld_r[NSTG-1] && out_ready;

  `OBPST_ASSERT_NOW(a_stall_only_full, clk, rst_n, 1'b1, ((~en & ~vld_r) == '0),
    "stage stalled while empty")
  `OBPST_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_acc, vld_r[0],
    "accepted beat missing from first stage")
  `OBPST_ASSERT_NEXT(a_beat_count, clk, rst_n, 1'b1,
    ($countones(vld_r) == $past($countones(vld_r)) + int'($past(in_acc)) - int'($past(out_acc))),
    "beats lost or repeated in pipeline")

endmodule

// ===== rtl/core/obpst_rot.sv =====
module obpst_rot (
  input  logic                                  clk,
  input  obpst_pkg::pipe_ctl_t                  ctl,
  input  logic        [obpst_pkg::POS_W-1:0]    pos_x,
  input  logic        [obpst_pkg::POS_W-1:0]    pos_y,
  input  logic        [obpst_pkg::POS_W-1:0]    pos_z,
  input  logic        [obpst_pkg::R_W-1:0]      radius,
  input  logic        [obpst_pkg::POS_W-1:0]    center_x,
  input  logic        [obpst_pkg::POS_W-1:0]    center_y,
  input  logic        [obpst_pkg::POS_W-1:0]    center_z,
  input  obpst_pkg::quat_conj_t                 quat,
  output logic signed [obpst_pkg::L_W-1:0]      loc_x,
  output logic signed [obpst_pkg::L_W-1:0]      loc_y,
  output logic signed [obpst_pkg::L_W-1:0]      loc_z,
  output logic        [obpst_pkg::R_W-1:0]      radius_o
);
  import obpst_pkg::*;

  logic signed [Q_W-1:0] qa, qb, qc, qw;

  logic signed [V_W-1:0] vx_nxt, vy_nxt, vz_nxt;
  logic signed [V_W-1:0] vx_r, vy_r, vz_r;
  logic signed [I_W-1:0] ix_nxt, iy_nxt, iz_nxt, iw_nxt;
  logic signed [I_W-1:0] ix_r, iy_r, iz_r, iw_r;
  logic signed [P_W-1:0] p_nxt [3][4];
  logic signed [P_W-1:0] p_r   [3][4];
  logic signed [S_W-1:0] s_sum [3];
  logic signed [L_W-1:0] l_nxt [3];
  logic signed [L_W-1:0] l_r   [3];
  logic [R_W-1:0]        rad_r [4];

  assign qa = quat.a;
  assign qb = quat.b;
  assign qc = quat.c;
  assign qw = quat.w;

  // stage 0: offset from box center
  always_comb begin
    vx_nxt = {pos_x[POS_W-1], pos_x} - {center_x[POS_W-1], center_x};
    vy_nxt = {pos_y[POS_W-1], pos_y} - {center_y[POS_W-1], center_y};
    vz_nxt = {pos_z[POS_W-1], pos_z} - {center_z[POS_W-1], center_z};
  end

  // stage 1: conj(q) * v
  always_comb begin
    ix_nxt = qw * vx_r + qb * vz_r - qc * vy_r;
    iy_nxt = qw * vy_r + qc * vx_r - qa * vz_r;
    iz_nxt = qw * vz_r + qa * vy_r - qb * vx_r;
    iw_nxt = -(qa * vx_r) - qb * vy_r - qc * vz_r;
  end

  // stage 2: partial products of (conj(q) * v) * q
  always_comb begin
    p_nxt[0][0] = ix_r * qw;  p_nxt[0][1] = iw_r * qa;
    p_nxt[0][2] = iy_r * qc;  p_nxt[0][3] = iz_r * qb;
    p_nxt[1][0] = iy_r * qw;  p_nxt[1][1] = iw_r * qb;
    p_nxt[1][2] = iz_r * qa;  p_nxt[1][3] = ix_r * qc;
    p_nxt[2][0] = iz_r * qw;  p_nxt[2][1] = iw_r * qc;
    p_nxt[2][2] = ix_r * qb;  p_nxt[2][3] = iy_r * qa;
  end

  // stage 3: sum and round half up back to Q8.8
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_sum[k] = p_r[k][0] - p_r[k][1] - p_r[k][2] + p_r[k][3] + RND_HALF;
      l_nxt[k] = s_sum[k][S_W-1:RND_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_DIFF]) begin
      vx_r     <= vx_nxt;
      vy_r     <= vy_nxt;
      vz_r     <= vz_nxt;
      rad_r[0] <= radius;
    end
    if (ctl.en[ST_INNER]) begin
      ix_r     <= ix_nxt;
      iy_r     <= iy_nxt;
      iz_r     <= iz_nxt;
      iw_r     <= iw_nxt;
      rad_r[1] <= rad_r[0];
    end
    if (ctl.en[ST_PROD]) begin
      p_r      <= p_nxt;
      rad_r[2] <= rad_r[1];
    end
    if (ctl.en[ST_ROUND]) begin
      l_r      <= l_nxt;
      rad_r[3] <= rad_r[2];
    end
  end

  assign loc_x    = l_r[0];
  assign loc_y    = l_r[1];
  assign loc_z    = l_r[2];
  assign radius_o = rad_r[3];

endmodule

// ===== rtl/core/obpst_dist.sv =====
module obpst_dist (
  input  logic                             clk,
  input  obpst_pkg::pipe_ctl_t             ctl,
  input  logic signed [obpst_pkg::L_W-1:0] loc_x,
  input  logic signed [obpst_pkg::L_W-1:0] loc_y,
  input  logic signed [obpst_pkg::L_W-1:0] loc_z,
  input  logic        [obpst_pkg::R_W-1:0] radius,
  input  obpst_pkg::half_ext_t             half,
  output logic                             inside_res,
  output logic                             overlaps
);
  import obpst_pkg::*;

  logic signed [L_W-1:0] l_in  [3];
  logic [L_W-1:0]        h_in  [3];
  logic [L_W-1:0]        mag   [3];
  logic                  in_ax [3];
  logic [L_W-1:0]        dm_nxt[3];
  logic [L_W-1:0]        dm_r  [3];
  logic                  ins_nxt;
  logic                  ins_r [3];
  logic [R_W-1:0]        rad_r;
  logic [SQ_W-1:0]       sq_r  [3];
  logic [R2_W-1:0]       r2_r;
  logic [D2_W-1:0]       d2;
  logic                  ovl_r;

  assign l_in[0] = loc_x;
  assign l_in[1] = loc_y;
  assign l_in[2] = loc_z;
  assign h_in[0] = L_W'(half.hx);
  assign h_in[1] = L_W'(half.hy);
  assign h_in[2] = L_W'(half.hz);

  // stage 4: distance past the face on each axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]    = l_in[k][L_W-1] ? L_W'(-l_in[k]) : L_W'(l_in[k]);
      in_ax[k]  = mag[k] <= h_in[k];
      dm_nxt[k] = in_ax[k] ? '0 : mag[k] - h_in[k];
    end
    ins_nxt = in_ax[0] && in_ax[1] && in_ax[2];
  end

  // stage 6: squared distance against squared radius
  assign d2 = D2_W'(sq_r[0]) + D2_W'(sq_r[1]) + D2_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_CLAMP]) begin
      dm_r     <= dm_nxt;
      ins_r[0] <= ins_nxt;
      rad_r    <= radius;
    end
    if (ctl.en[ST_SQ]) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= SQ_W'(dm_r[k]) * SQ_W'(dm_r[k]);
      end
      r2_r     <= R2_W'(rad_r) * R2_W'(rad_r);
      ins_r[1] <= ins_r[0];
    end
    if (ctl.en[ST_SUM]) begin
      ovl_r    <= d2 <= D2_W'(r2_r);
      ins_r[2] <= ins_r[1];
    end
  end

  assign inside_res = ins_r[2];
  assign overlaps   = ovl_r;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import obpst_pkg::*;

  // a quiet stretch this long means the block has hung
  localparam int WATCHDOG_LIMIT  = 2000;
  // long receiver hold-off used to fill the pipeline and stall the input
  localparam int HOLD_OFF_CYCLES = 100;
  // reset orientation: z = 0 in the low half, w = 1.0 in the high half
  localparam logic [31:0] IDENTITY_ZW = 32'h4000_0000;
  // 90 degree turn about z: z = w = cos 45 in Q1.14
  localparam logic [31:0] QUARTER_TURN_ZW = {16'sd11585, 16'sd11585};

  // shadow of the box registers
  typedef struct {
    logic signed [POS_W-1:0] cx, cy, cz;
    logic [H_W-1:0]          hx, hy, hz;
    logic [CFG_W-1:0]        qxy, qzw;
  } box_t;

  // one query together with the flags it should produce
  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    logic [R_W-1:0]          r;
    logic                    inside_res;
    logic                    overlaps;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // in_tdata: pos_x [15:0], pos_y [31:16], pos_z [47:32], radius [62:48], zero pad [63]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: inside_res [0], overlaps [1], zero pad [7:2]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [IDX_W-1:0]       cfg_addr = CFG_CENTER_X;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // box as the block holds it, starting from its reset values
  box_t box = '{cx: 0, cy: 0, cz: 0, hx: 256, hy: 256, hz: 256, qxy: '0, qzw: IDENTITY_ZW};

  verdict_t verdicts_due[$];

  // pacing controls shared with the traffic processes
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_off_req = 1'b0;

  int n_errors     = 0;
  int n_queries    = 0;
  int n_results    = 0;
  int n_inside     = 0;
  int n_overlap    = 0;
  int n_boxes      = 0;
  int n_stalled    = 0;
  int quiet_cycles = 0;

  oriented_box_point_sphere_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // distance of a local coordinate beyond the symmetric half extent
  function automatic longint beyond_half(longint v, longint h);
    if (v > h) return v - h;
    if (v < -h) return v + h;
    return 0;
  endfunction

  function automatic longint abs_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // rotate the offset from the center into box-local space and test it
  function automatic verdict_t box_verdict(box_t b, logic signed [POS_W-1:0] px,
                                           logic signed [POS_W-1:0] py,
                                           logic signed [POS_W-1:0] pz,
                                           logic [R_W-1:0] r);
    verdict_t v;
    longint dx, dy, dz;
    longint ca, cb, cc, cw;
    longint ix, iy, iz, iw;
    longint lx, ly, lz;
    longint hx, hy, hz;
    longint ex, ey, ez;
    longint half_lsb;
    half_lsb = longint'(1) <<< (RND_SH - 1);
    dx = longint'(px) - longint'(b.cx);
    dy = longint'(py) - longint'(b.cy);
    dz = longint'(pz) - longint'(b.cz);
    // conjugate of the box orientation
    ca = -longint'($signed(b.qxy[15:0]));
    cb = -longint'($signed(b.qxy[31:16]));
    cc = -longint'($signed(b.qzw[15:0]));
    cw =  longint'($signed(b.qzw[31:16]));
    // q* v, with v a pure quaternion
    ix = cw * dx + cb * dz - cc * dy;
    iy = cw * dy + cc * dx - ca * dz;
    iz = cw * dz + ca * dy - cb * dx;
    iw = -ca * dx - cb * dy - cc * dz;
    // (q* v) q, rounded half up from Q.36 to Q8.8
    lx = (ix * cw - iw * ca - iy * cc + iz * cb + half_lsb) >>> RND_SH;
    ly = (iy * cw - iw * cb - iz * ca + ix * cc + half_lsb) >>> RND_SH;
    lz = (iz * cw - iw * cc - ix * cb + iy * ca + half_lsb) >>> RND_SH;
    hx = longint'(b.hx);
    hy = longint'(b.hy);
    hz = longint'(b.hz);
    ex = beyond_half(lx, hx);
    ey = beyond_half(ly, hy);
    ez = beyond_half(lz, hz);
    v.px = px;
    v.py = py;
    v.pz = pz;
    v.r  = r;
    v.inside_res = (abs_of(lx) <= hx) && (abs_of(ly) <= hy) && (abs_of(lz) <= hz);
    v.overlaps   = (ex * ex + ey * ey + ez * ez) <= (longint'(r) * longint'(r));
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // monitors
  // ---------------------------------------------------------------------------

  // every accepted query beat books its expected flags
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      verdicts_due.insert(verdicts_due.size(),
                          box_verdict(box, $signed(in_tdata[15:0]),
                                      $signed(in_tdata[31:16]),
                                      $signed(in_tdata[47:32]), in_tdata[62:48]));
    if (rst_n && in_tvalid && !in_tready)
      n_stalled++;
  end

  task automatic log_error(string what);
    n_errors++;
    if (n_errors <= 10)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // result beats are matched in order against the oldest booking
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (verdicts_due.size() == 0) begin
        log_error($sformatf("result beat with nothing pending, tdata %02h", out_tdata));
      end else begin
        exp_v = verdicts_due.pop_front();
        n_inside  += exp_v.inside_res;
        n_overlap += exp_v.overlaps;
        if (out_tdata[0] !== exp_v.inside_res || out_tdata[1] !== exp_v.overlaps)
          log_error($sformatf(
            "pos (%0d,%0d,%0d) r %0d: inside_res exp %0b got %0b, overlaps exp %0b got %0b",
            exp_v.px, exp_v.py, exp_v.pz, exp_v.r, exp_v.inside_res, out_tdata[0],
            exp_v.overlaps, out_tdata[1]));
      end
    end
  end

  // hang detector: no beat on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 quiet_cycles, verdicts_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver pacing: random ready/idle runs, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_pacing
    int run_left;
    bit run_ready;
    run_left  = 0;
    run_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // count the hold-off here so the sender keeps pushing meanwhile
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          // never two idle runs in a row, so busy stretches stay visible
          run_ready = !sink_idle_en || !run_ready || ($urandom_range(0, 2) != 0);
          run_left  = run_ready ? $urandom_range(1, 40) : $urandom_range(1, 19);
        end
        if (!sink_idle_en)
          run_ready = 1'b1;
        out_tready <= run_ready;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared driving tasks
  // ---------------------------------------------------------------------------

  // offer one query beat, maybe after an idle burst, and return once taken
  task automatic send_query(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                            logic signed [POS_W-1:0] pz, logic [R_W-1:0] r);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, r, pz, py, px};
    do @(posedge clk); while (!in_tready);
    n_queries++;
  endtask

  // stop offering and wait until every booked result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    // step past the last accepting edge first so its booking is in the queue
    do @(posedge clk); while (verdicts_due.size() != 0);
    @(posedge clk);
  endtask

  // load all eight registers while idle; junk above each width must be dropped
  task automatic apply_box(box_t b);
    cfg_idx_t idx;
    logic [CFG_W-1:0] word;
    drain();
    idx = idx.first();
    repeat (8) begin
      case (idx)
        CFG_CENTER_X: word = {16'($urandom), b.cx};
        CFG_CENTER_Y: word = {16'($urandom), b.cy};
        CFG_CENTER_Z: word = {16'($urandom), b.cz};
        CFG_HALF_X:   word = {17'($urandom), b.hx};
        CFG_HALF_Y:   word = {17'($urandom), b.hy};
        CFG_HALF_Z:   word = {17'($urandom), b.hz};
        CFG_QUAT_XY:  word = b.qxy;
        default:      word = b.qzw;
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= word;
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    box = b;
    n_boxes++;
  endtask

  function automatic logic signed [POS_W-1:0] clip_pos(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return POS_W'(v);
  endfunction

  function automatic box_t random_box();
    box_t b;
    real q[4];
    real norm;
    int kind;
    kind = $urandom_range(0, 9);
    b.cx = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000);
    b.cy = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000);
    b.cz = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000);
    // mostly modest extents, now and then flat or huge
    b.hx = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3000));
    b.hy = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3000));
    b.hz = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3000));
    if (kind == 0) begin
      // raw bits: scaling rotation or worse
      b.qxy = $urandom;
      b.qzw = $urandom;
    end else if (kind == 1) begin
      b.qxy = '0;
      b.qzw = IDENTITY_ZW;
    end else begin
      norm = 0.0;
      foreach (q[k]) begin
        q[k] = real'(int'($urandom_range(0, 2000)) - 1000);
        norm += q[k] * q[k];
      end
      norm = $sqrt(norm);
      if (norm < 1.0) begin
        q = '{0.0, 0.0, 0.0, 1.0};
        norm = 1.0;
      end
      b.qxy = {16'($rtoi(q[1] / norm * 16384.0)), 16'($rtoi(q[0] / norm * 16384.0))};
      b.qzw = {16'($rtoi(q[3] / norm * 16384.0)), 16'($rtoi(q[2] / norm * 16384.0))};
    end
    return b;
  endfunction

  // queries mostly scattered around the current box, some anywhere at all
  task automatic run_queries(int count);
    int reach;
    int hmax;
    repeat (count) begin
      hmax  = (box.hx > box.hy) ? box.hx : box.hy;
      hmax  = (box.hz > hmax) ? box.hz : hmax;
      reach = 2 * hmax + 256;
      if ($urandom_range(0, 4) == 0)
        send_query(16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom));
      else
        send_query(clip_pos(longint'(box.cx) + $urandom_range(0, 2 * reach) - reach),
                   clip_pos(longint'(box.cy) + $urandom_range(0, 2 * reach) - reach),
                   clip_pos(longint'(box.cz) + $urandom_range(0, 2 * reach) - reach),
                   ($urandom_range(0, 5) == 0) ? 15'd0 : 15'($urandom_range(0, reach / 2)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // unit box at the origin straight out of reset, no register writes
  task automatic test_reset_box();
    send_query(0, 0, 0, 0);
    send_query(256, -256, 256, 0);            // corner counts as inside
    send_query(257, 0, 0, 0);                 // one lsb out
    send_query(257, 0, 0, 1);                 // distance equals radius
    send_query(0, 0, -258, 1);
    send_query(0, 0, -258, 2);
    send_query(32767, 32767, 32767, 32767);
    send_query(-32768, -32768, -32768, 0);
  endtask

  // extreme centers, zero and full extents, turned, zero and saturated orientations
  task automatic test_extreme_boxes();
    apply_box('{cx: -32768, cy: 32767, cz: 0, hx: 0, hy: 32767, hz: 0,
                qxy: '0, qzw: QUARTER_TURN_ZW});
    send_query(32767, -32768, 0, 32767);      // widest offset from the center
    send_query(-32768, 32767, 0, 0);          // flat box still holds its center
    send_query(-32768, 32767, 1, 0);
    send_query(-32767, 32767, 0, 1);
    // zero orientation collapses every point onto the center
    apply_box('{cx: 0, cy: 0, cz: 0, hx: 0, hy: 0, hz: 0, qxy: '0, qzw: '0});
    send_query(32767, -32768, 12345, 0);
    send_query(-1, -1, -1, 0);
    // most negative parts, whose negation needs the extra bit
    apply_box('{cx: 32767, cy: 32767, cz: 32767, hx: 32767, hy: 32767, hz: 32767,
                qxy: 32'h8000_8000, qzw: 32'h8000_7fff});
    send_query(-32768, -32768, -32768, 32767);
    send_query(32767, 32767, 32767, 0);
    send_query(0, 0, 0, 0);
    send_query(-32768, 32767, 0, 12345);
    apply_box('{cx: 0, cy: 0, cz: 0, hx: 32767, hy: 32767, hz: 32767,
                qxy: '0, qzw: IDENTITY_ZW});
    send_query(32767, -32768, 32767, 0);      // one lsb beyond the largest extent
    send_query(32767, -32768, 32767, 1);
  endtask

  task automatic test_random_boxes(int phases, int per_box);
    repeat (phases) begin
      apply_box(random_box());
      run_queries(per_box);
    end
  endtask

  // receiver holds off while the sender streams, so the input must stall
  task automatic test_back_pressure();
    apply_box(random_box());
    src_idle_en  = 1'b0;
    hold_off_req = 1'b1;
    run_queries(40);
    drain();
    src_idle_en = 1'b1;
  endtask

  // closing stretch at full rate with no idling on either side
  task automatic test_steady_stream();
    apply_box(random_box());
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_queries(150);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_box();
    test_extreme_boxes();
    test_random_boxes(8, 100);
    test_back_pressure();
    test_steady_stream();

    // let the pipeline empty out, then keep watching for stray beats
    drain();
    repeat (NSTG + 3) @(posedge clk);
    if (verdicts_due.size() != 0)
      log_error($sformatf("%0d results never arrived", verdicts_due.size()));

    $display("covered %0d queries on %0d box settings, %0d results: %0d inside, %0d overlapping",
             n_queries, n_boxes + 1, n_results, n_inside, n_overlap);
    $display("input held off for %0d cycles under back pressure, %0d errors",
             n_stalled, n_errors);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/obpst_pkg.sv
rtl/core/obpst_ctl.sv
rtl/core/obpst_rot.sv
rtl/core/obpst_dist.sv
rtl/core/oriented_box_point_sphere_test.sv
sim/tb_top.sv
